>>> hw/rtl/cfts_pkg.sv
// ----------------------------------------------------------------------------
// cfts_pkg
// Shared widths, register indexes, commands and types of the coarse/fine
// tuning search block.
// ----------------------------------------------------------------------------
package cfts_pkg;

  localparam int DAC_BITS   = 8;
  localparam int TRY_W      = ((DAC_BITS > 8) ? DAC_BITS : 8) + 1;
  localparam int AMP_W      = 8;
  localparam int PH_W       = 8;
  localparam int CS_W       = 8;
  localparam int FS_W       = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (DAC_BITS > CS_W) ? DAC_BITS : CS_W;
  localparam int IN_DATA_W  = AMP_W + PH_W;
  localparam int OUT_DATA_W = 2 * DAC_BITS + AMP_W + PH_W;

  localparam logic [CFG_IDX_W-1:0] REG_COARSE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FINE_STEP   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DAC = CFG_IDX_W'(2);

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_MEASURE = 1'b1;

  localparam logic [CS_W-1:0]     COARSE_STEP_RST = CS_W'(16);
  localparam logic [FS_W-1:0]     FINE_STEP_RST   = FS_W'(4);
  localparam logic [DAC_BITS-1:0] DEFAULT_DAC_RST = DAC_BITS'(1 << (DAC_BITS - 1));

  typedef struct packed {
    logic [CS_W-1:0]     coarse_step;
    logic [FS_W-1:0]     fine_step;
    logic [DAC_BITS-1:0] default_dac;
  } cfts_cfg_t;

  typedef struct packed {
    logic [PH_W-1:0]     best_phase;
    logic [AMP_W-1:0]    best_amplitude;
    logic [DAC_BITS-1:0] dac_b;
    logic [DAC_BITS-1:0] dac_a;
    logic                done_res;
  } cfts_res_t;

endpackage

>>> hw/rtl/cfts_cfg_regs.sv
// ----------------------------------------------------------------------------
// cfts_cfg_regs
// Configuration register file: coarse step, fine step and default pair value.
// ----------------------------------------------------------------------------
module cfts_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [cfts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfts_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cfts_pkg::cfts_cfg_t              cfg
);
  import cfts_pkg::*;

  cfts_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coarse_step <= COARSE_STEP_RST;
      cfg_r.fine_step   <= FINE_STEP_RST;
      cfg_r.default_dac <= DEFAULT_DAC_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COARSE_STEP: cfg_r.coarse_step <= cfg_data[CS_W-1:0];
        REG_FINE_STEP:   cfg_r.fine_step   <= cfg_data[FS_W-1:0];
        REG_DEFAULT_DAC: cfg_r.default_dac <= cfg_data[DAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/cfts_search.sv
// ----------------------------------------------------------------------------
// cfts_search
// Search state and next-pair logic: coarse grid, fine window, best tracking.
// ----------------------------------------------------------------------------
module cfts_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic                          cmd,
  input  logic [cfts_pkg::AMP_W-1:0]    amplitude,
  input  logic [cfts_pkg::PH_W-1:0]     phase,
  input  cfts_pkg::cfts_cfg_t           cfg,
  output cfts_pkg::cfts_res_t           res
);
  import cfts_pkg::*;

  typedef enum logic [1:0] {MODE_IDLE, MODE_COARSE, MODE_FINE} mode_t;

  localparam logic [TRY_W-1:0] DAC_MAX = TRY_W'((1 << DAC_BITS) - 1);

  mode_t               mode_r, mode_nxt;
  logic [TRY_W-1:0]    try_a_r, try_a_nxt, try_b_r, try_b_nxt;
  logic [DAC_BITS-1:0] best_a_r, best_a_nxt, best_b_r, best_b_nxt;
  logic [AMP_W-1:0]    top_amp_r, top_amp_nxt;
  logic [PH_W-1:0]     top_ph_r, top_ph_nxt;
  logic [DAC_BITS-1:0] win_a_end_r, win_a_end_nxt;
  logic [DAC_BITS-1:0] win_b_start_r, win_b_start_nxt;
  logic [DAC_BITS-1:0] win_b_end_r, win_b_end_nxt;

  logic [CS_W-1:0]     cs;
  logic [FS_W-1:0]     fs;
  logic [TRY_W-1:0]    cs_ext, fs_ext;
  logic                rec;
  logic [DAC_BITS-1:0] rb_a, rb_b;
  logic [AMP_W-1:0]    r_amp;
  logic [PH_W-1:0]     r_ph;
  logic [TRY_W-1:0]    lo_a, lo_b, hi_a_sum, hi_b_sum, hi_a, hi_b;
  logic [TRY_W-1:0]    a_sum, b_sum;

  always_comb begin
    cs     = (cfg.coarse_step == '0) ? CS_W'(1) : cfg.coarse_step;
    fs     = (cfg.fine_step == '0) ? FS_W'(1) : cfg.fine_step;
    cs_ext = TRY_W'(cs);
    fs_ext = TRY_W'(fs);

    // best after this measurement, strictly greater wins
    rec   = amplitude > top_amp_r;
    rb_a  = rec ? try_a_r[DAC_BITS-1:0] : best_a_r;
    rb_b  = rec ? try_b_r[DAC_BITS-1:0] : best_b_r;
    r_amp = rec ? amplitude : top_amp_r;
    r_ph  = rec ? phase : top_ph_r;

    // fine window around the best, clamped
    lo_a     = (TRY_W'(rb_a) > cs_ext) ? TRY_W'(rb_a) - cs_ext : '0;
    lo_b     = (TRY_W'(rb_b) > cs_ext) ? TRY_W'(rb_b) - cs_ext : '0;
    hi_a_sum = TRY_W'(rb_a) + cs_ext;
    hi_b_sum = TRY_W'(rb_b) + cs_ext;
    hi_a     = (hi_a_sum > DAC_MAX) ? DAC_MAX : hi_a_sum;
    hi_b     = (hi_b_sum > DAC_MAX) ? DAC_MAX : hi_b_sum;

    a_sum = try_a_r;
    b_sum = try_b_r;

    mode_nxt        = mode_r;
    try_a_nxt       = try_a_r;
    try_b_nxt       = try_b_r;
    best_a_nxt      = best_a_r;
    best_b_nxt      = best_b_r;
    top_amp_nxt     = top_amp_r;
    top_ph_nxt      = top_ph_r;
    win_a_end_nxt   = win_a_end_r;
    win_b_start_nxt = win_b_start_r;
    win_b_end_nxt   = win_b_end_r;

    res.dac_a          = best_a_r;
    res.dac_b          = best_b_r;
    res.done_res       = 1'b1;
    res.best_amplitude = top_amp_r;
    res.best_phase     = top_ph_r;

    if (cmd == CMD_START) begin
      mode_nxt    = MODE_COARSE;
      try_a_nxt   = '0;
      try_b_nxt   = '0;
      best_a_nxt  = cfg.default_dac;
      best_b_nxt  = cfg.default_dac;
      top_amp_nxt = '0;
      top_ph_nxt  = '0;
      res         = '0;
    end else begin
      case (mode_r)
        MODE_COARSE: begin
          best_a_nxt  = rb_a;
          best_b_nxt  = rb_b;
          top_amp_nxt = r_amp;
          top_ph_nxt  = r_ph;
          b_sum       = try_b_r + cs_ext;
          if (b_sum > DAC_MAX) begin
            try_b_nxt = '0;
            a_sum     = try_a_r + cs_ext;
          end else begin
            try_b_nxt = b_sum;
          end
          if (a_sum > DAC_MAX) begin
            try_a_nxt       = lo_a;
            try_b_nxt       = lo_b;
            win_a_end_nxt   = hi_a[DAC_BITS-1:0];
            win_b_start_nxt = lo_b[DAC_BITS-1:0];
            win_b_end_nxt   = hi_b[DAC_BITS-1:0];
            mode_nxt        = MODE_FINE;
          end else begin
            try_a_nxt = a_sum;
          end
          res.dac_a          = try_a_nxt[DAC_BITS-1:0];
          res.dac_b          = try_b_nxt[DAC_BITS-1:0];
          res.done_res       = 1'b0;
          res.best_amplitude = r_amp;
          res.best_phase     = r_ph;
        end
        MODE_FINE: begin
          best_a_nxt  = rb_a;
          best_b_nxt  = rb_b;
          top_amp_nxt = r_amp;
          top_ph_nxt  = r_ph;
          b_sum       = try_b_r + fs_ext;
          if (b_sum > TRY_W'(win_b_end_r)) begin
            try_b_nxt = TRY_W'(win_b_start_r);
            a_sum     = try_a_r + fs_ext;
          end else begin
            try_b_nxt = b_sum;
          end
          try_a_nxt          = a_sum;
          res.best_amplitude = r_amp;
          res.best_phase     = r_ph;
          if (a_sum > TRY_W'(win_a_end_r)) begin
            mode_nxt     = MODE_IDLE;
            res.dac_a    = rb_a;
            res.dac_b    = rb_b;
            res.done_res = 1'b1;
          end else begin
            res.dac_a    = try_a_nxt[DAC_BITS-1:0];
            res.dac_b    = try_b_nxt[DAC_BITS-1:0];
            res.done_res = 1'b0;
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      try_a_r       <= '0;
      try_b_r       <= '0;
      best_a_r      <= DEFAULT_DAC_RST;
      best_b_r      <= DEFAULT_DAC_RST;
      top_amp_r     <= '0;
      top_ph_r      <= '0;
      win_a_end_r   <= '0;
      win_b_start_r <= '0;
      win_b_end_r   <= '0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      try_a_r       <= try_a_nxt;
      try_b_r       <= try_b_nxt;
      best_a_r      <= best_a_nxt;
      best_b_r      <= best_b_nxt;
      top_amp_r     <= top_amp_nxt;
      top_ph_r      <= top_ph_nxt;
      win_a_end_r   <= win_a_end_nxt;
      win_b_start_r <= win_b_start_nxt;
      win_b_end_r   <= win_b_end_nxt;
    end
  end

endmodule

>>> hw/rtl/coarse_fine_tuning_search.sv
// ----------------------------------------------------------------------------
// coarse_fine_tuning_search
// Coarse/fine grid search sequencer for a pair of tuning DAC values.
// ----------------------------------------------------------------------------
// Send a start beat (tuser 0) to get the first pair, then one measurement
// beat (tuser 1) per pair applied; each beat returns exactly one result beat
// with the next pair, or the best pair with done set once the fine window is
// exhausted. The block takes one beat per clock: an input register feeds the
// search state update, whose result lands in the output register, so each
// input beat passes through the input register and then the output register,
// and the input stalls only when both registers are full and the output is
// not being read.
// Configuration writes are accepted in any cycle; cfg_ready is always high.
module coarse_fine_tuning_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cfts_pkg::IN_DATA_W-1:0]   in_tdata,   // amplitude, phase
  input  logic                             in_tuser,   // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cfts_pkg::OUT_DATA_W-1:0]  out_tdata,  // dac_a, dac_b, best_amplitude, best_phase
  output logic                             out_tuser,  // done_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfts_pkg::*;

  cfts_cfg_t        cfg;
  cfts_res_t        res;
  logic             in_valid_r;
  logic             in_cmd_r;
  logic [AMP_W-1:0] in_amp_r;
  logic [PH_W-1:0]  in_ph_r;
  logic             out_valid_r;
  cfts_res_t        out_res_r;
  logic             advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  cfts_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfts_search u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .cmd       (in_cmd_r),
    .amplitude (in_amp_r),
    .phase     (in_ph_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r <= in_tuser;
      in_amp_r <= in_tdata[AMP_W-1:0];
      in_ph_r  <= in_tdata[AMP_W +: PH_W];
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.done_res;
  assign out_tdata  = {out_res_r.best_phase, out_res_r.best_amplitude,
                       out_res_r.dac_b, out_res_r.dac_a};

endmodule

>>> hw/rtl/cfts_checker.sv
// ----------------------------------------------------------------------------
// cfts_checker
// Port-level checks of the tuning search, bound to the top level.
// ----------------------------------------------------------------------------
module cfts_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [cfts_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import cfts_pkg::*;

  logic [DAC_BITS-1:0] dac_a, dac_b;
  logic [AMP_W-1:0]    best_amp;
  logic [PH_W-1:0]     best_ph;
  logic [AMP_W-1:0]    prev_amp_r;

  assign dac_a    = out_tdata[DAC_BITS-1:0];
  assign dac_b    = out_tdata[DAC_BITS +: DAC_BITS];
  assign best_amp = out_tdata[2*DAC_BITS +: AMP_W];
  assign best_ph  = out_tdata[2*DAC_BITS+AMP_W +: PH_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_amp_r <= '0;
    end else if (out_tvalid && out_tready) begin
      prev_amp_r <= best_amp;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_zero_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && best_amp == '0 |-> best_ph == '0)
    else $error("phase recorded without an amplitude above zero");

  // best amplitude only falls on the first beat of a new search
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && best_amp < prev_amp_r
      |-> dac_a == '0 && dac_b == '0 && !out_tuser && best_amp == '0)
    else $error("best amplitude dropped inside a search");

endmodule

bind coarse_fine_tuning_search cfts_checker u_cfts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/coarse_fine_tuning_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coarse_fine_tuning_search_tb
// Self-checking bench for the coarse/fine tuning search. A directed table
// covers idle reads, restarts, odd step values and the default pair; then
// random searches run under several register settings with random gaps on
// both streams and one long output stall. Every result beat is compared
// field by field against a local model of the search or a table entry.
// ----------------------------------------------------------------------------
module coarse_fine_tuning_search_tb;
  import cfts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);
  localparam logic [TRY_W-1:0] DAC_TOP = TRY_W'((1 << DAC_BITS) - 1);
  localparam int ITEM_GOAL = 1550;
  localparam int SETTLE_CYC = 4;

  typedef enum logic [1:0] {SWEEP_IDLE, SWEEP_COARSE, SWEEP_FINE} sweep_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  cmd;
    logic [AMP_W-1:0]      amp;
    logic [PH_W-1:0]       ph;
    logic [7:0]            reps;
    logic                  known;
    cfts_res_t             want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // amplitude, phase
  logic                  in_tuser;   // cmd
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // dac_a, dac_b, best_amplitude, best_phase
  logic                  out_tuser;  // done_res
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  coarse_fine_tuning_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // search model state
  logic [CS_W-1:0]     cfg_coarse;
  logic [FS_W-1:0]     cfg_fine;
  logic [DAC_BITS-1:0] cfg_default;
  sweep_t              sweep_mode;
  logic [TRY_W-1:0]    pos_a, pos_b;
  logic [DAC_BITS-1:0] peak_a, peak_b;
  logic [AMP_W-1:0]    peak_amp;
  logic [PH_W-1:0]     peak_ph;
  logic [DAC_BITS-1:0] fine_a_end, fine_b_lo, fine_b_hi;

  cfts_res_t tuning_q[$];
  plan_row_t plan[$];
  cfts_res_t want_r;
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  bit        stall_done = 0;
  bit        cfg_open = 0;

  function automatic logic [DAC_BITS-1:0] win_lo(input logic [DAC_BITS-1:0] c,
                                                 input logic [TRY_W-1:0] half);
    return ({1'b0, c} > half) ? DAC_BITS'({1'b0, c} - half) : '0;
  endfunction

  function automatic logic [DAC_BITS-1:0] win_hi(input logic [DAC_BITS-1:0] c,
                                                 input logic [TRY_W-1:0] half);
    logic [TRY_W-1:0] s;
    s = {1'b0, c} + half;
    return (s > DAC_TOP) ? DAC_BITS'(DAC_TOP) : DAC_BITS'(s);
  endfunction

  function automatic cfts_res_t next_tuning(input logic cmd, input logic [AMP_W-1:0] amp,
                                            input logic [PH_W-1:0] ph);
    logic [TRY_W-1:0] cs, fs;
    cfts_res_t r;
    cs = (cfg_coarse == 0) ? TRY_W'(1) : TRY_W'(cfg_coarse);
    fs = (cfg_fine == 0) ? TRY_W'(1) : TRY_W'(cfg_fine);
    r = '0;
    if (cmd == CMD_START) begin
      peak_a = cfg_default;
      peak_b = cfg_default;
      peak_amp = '0;
      peak_ph = '0;
      pos_a = '0;
      pos_b = '0;
      sweep_mode = SWEEP_COARSE;
    end else if (sweep_mode == SWEEP_IDLE) begin
      r.done_res = 1'b1;
    end else begin
      if (amp > peak_amp) begin
        peak_amp = amp;
        peak_ph = ph;
        peak_a = DAC_BITS'(pos_a);
        peak_b = DAC_BITS'(pos_b);
      end
      if (sweep_mode == SWEEP_COARSE) begin
        pos_b = pos_b + cs;
        if (pos_b > DAC_TOP) begin
          pos_b = '0;
          pos_a = pos_a + cs;
        end
        if (pos_a > DAC_TOP) begin
          pos_a = TRY_W'(win_lo(peak_a, cs));
          fine_a_end = win_hi(peak_a, cs);
          fine_b_lo = win_lo(peak_b, cs);
          fine_b_hi = win_hi(peak_b, cs);
          pos_b = TRY_W'(fine_b_lo);
          sweep_mode = SWEEP_FINE;
        end
      end else begin
        pos_b = pos_b + fs;
        if (pos_b > TRY_W'(fine_b_hi)) begin
          pos_b = TRY_W'(fine_b_lo);
          pos_a = pos_a + fs;
        end
        if (pos_a > TRY_W'(fine_a_end)) begin
          sweep_mode = SWEEP_IDLE;
          r.done_res = 1'b1;
        end
      end
    end
    if (r.done_res) begin
      r.dac_a = peak_a;
      r.dac_b = peak_b;
    end else begin
      r.dac_a = DAC_BITS'(pos_a);
      r.dac_b = DAC_BITS'(pos_b);
    end
    r.best_amplitude = peak_amp;
    r.best_phase = peak_ph;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (tuning_q.size() == 0) begin
        note_mismatch("unexpected result beat", 1, 0);
      end else begin
        want_r = tuning_q.pop_front();
        if (out_tdata[DAC_BITS-1:0] !== want_r.dac_a)
          note_mismatch("dac_a", out_tdata[DAC_BITS-1:0], want_r.dac_a);
        if (out_tdata[2*DAC_BITS-1:DAC_BITS] !== want_r.dac_b)
          note_mismatch("dac_b", out_tdata[2*DAC_BITS-1:DAC_BITS], want_r.dac_b);
        if (out_tuser !== want_r.done_res)
          note_mismatch("done_res", out_tuser, want_r.done_res);
        if (out_tdata[2*DAC_BITS+AMP_W-1:2*DAC_BITS] !== want_r.best_amplitude)
          note_mismatch("best_amplitude", out_tdata[2*DAC_BITS+AMP_W-1:2*DAC_BITS],
                        want_r.best_amplitude);
        if (out_tdata[OUT_DATA_W-1:2*DAC_BITS+AMP_W] !== want_r.best_phase)
          note_mismatch("best_phase", out_tdata[OUT_DATA_W-1:2*DAC_BITS+AMP_W],
                        want_r.best_phase);
      end
    end
  end

  // result sink: random stalls, one long hold-off
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!stall_done && results_seen >= 400) begin
        stall_done = 1;
        out_tready <= 1'b0;
        repeat (64) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= (items_sent >= 700 && items_sent < 1000) || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endtask

  task automatic add_beat(input logic cmd, input logic [AMP_W-1:0] amp,
                          input logic [PH_W-1:0] ph, input int reps);
    plan_row_t r;
    r = '0;
    r.cmd = cmd;
    r.amp = amp;
    r.ph = ph;
    r.reps = 8'(reps);
    plan.push_back(r);
  endtask

  task automatic add_known(input logic cmd, input logic [AMP_W-1:0] amp,
                           input logic [PH_W-1:0] ph, input logic [DAC_BITS-1:0] a,
                           input logic [DAC_BITS-1:0] b, input logic done,
                           input logic [AMP_W-1:0] bamp, input logic [PH_W-1:0] bph);
    plan_row_t r;
    r = '0;
    r.cmd = cmd;
    r.amp = amp;
    r.ph = ph;
    r.reps = 8'd1;
    r.known = 1'b1;
    r.want.dac_a = a;
    r.want.dac_b = b;
    r.want.done_res = done;
    r.want.best_amplitude = bamp;
    r.want.best_phase = bph;
    plan.push_back(r);
  endtask

  // called at a falling edge, returns at a falling edge with in_tvalid high
  task automatic send_beat(input logic cmd, input logic [AMP_W-1:0] amp,
                           input logic [PH_W-1:0] ph, input logic known,
                           input cfts_res_t want);
    cfts_res_t pred;
    while (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {ph, amp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = next_tuning(cmd, amp, ph);
    tuning_q.push_back(known ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (tuning_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_COARSE_STEP: cfg_coarse = val[CS_W-1:0];
      REG_FINE_STEP:   cfg_fine = val[FS_W-1:0];
      REG_DEFAULT_DAC: cfg_default = val[DAC_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [AMP_W-1:0] pick_amp();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2) return '0;
    if (r == 2) return peak_amp;
    if (r == 3) return '1;
    return AMP_W'($urandom_range(0, 255));
  endfunction

  task automatic run_search(input int cap);
    int n;
    n = 0;
    send_beat(CMD_START, AMP_W'($urandom_range(0, 255)), PH_W'($urandom_range(0, 255)),
              1'b0, '0);
    while (sweep_mode != SWEEP_IDLE && n < cap) begin
      send_beat(CMD_MEASURE, pick_amp(), PH_W'($urandom_range(0, 255)), 1'b0, '0);
      n++;
    end
  endtask

  initial begin
    int phase_no;
    int cs, fs, dflt, nsearch;
    plan_row_t row;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cfg_coarse = COARSE_STEP_RST;
    cfg_fine = FINE_STEP_RST;
    cfg_default = DEFAULT_DAC_RST;
    sweep_mode = SWEEP_IDLE;
    pos_a = '0;
    pos_b = '0;
    peak_a = DEFAULT_DAC_RST;
    peak_b = DEFAULT_DAC_RST;
    peak_amp = '0;
    peak_ph = '0;
    fine_a_end = '0;
    fine_b_lo = '0;
    fine_b_hi = '0;

    // directed table
    add_cfg(REG_NONE, 8'hAA);
    add_known(CMD_MEASURE, 8'hFF, 8'hFF, 8'd128, 8'd128, 1'b1, 8'd0, 8'd0);
    add_cfg(REG_COARSE_STEP, 8'd200);
    add_cfg(REG_FINE_STEP, 8'd0);
    add_cfg(REG_DEFAULT_DAC, 8'd255);
    add_known(CMD_START, 8'h12, 8'h34, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    add_beat(CMD_MEASURE, 8'h00, 8'hFF, 5);
    add_known(CMD_START, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    add_cfg(REG_COARSE_STEP, 8'd128);
    add_cfg(REG_FINE_STEP, 8'd64);
    add_beat(CMD_MEASURE, 8'h00, 8'h5A, 12);
    add_known(CMD_MEASURE, 8'h00, 8'hA5, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0);
    add_known(CMD_MEASURE, 8'hFF, 8'h77, 8'd255, 8'd255, 1'b1, 8'd0, 8'd0);
    add_cfg(REG_DEFAULT_DAC, 8'd0);
    add_known(CMD_START, 8'hC3, 8'h3C, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
    add_beat(CMD_MEASURE, 8'h80, 8'h11, 1);
    add_beat(CMD_MEASURE, 8'h80, 8'h22, 1);
    add_beat(CMD_MEASURE, 8'hFF, 8'hFF, 1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        if (!cfg_open) drain();
        cfg_open = 1;
        cfg_write(row.idx, row.val);
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 0;
        repeat (row.reps) send_beat(row.cmd, row.amp, row.ph, row.known, row.want);
      end
    end

    // random searches under changing settings
    phase_no = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase_no)
        0: begin cs = 255; fs = 255; dflt = 0; end
        1: begin cs = 0; fs = 0; dflt = 255; end
        2: begin cs = 1; fs = 1; dflt = 1; end
        default: begin
          case ($urandom_range(0, 9))
            0: cs = $urandom_range(129, 255);
            1: cs = $urandom_range(0, 23);
            default: cs = $urandom_range(24, 128);
          endcase
          if ($urandom_range(0, 9) == 0)
            fs = 0;
          else
            fs = $urandom_range((cs < 8) ? 1 : ((cs / 4 > 127) ? 127 : cs / 4), 127);
          fs = fs | ($urandom_range(0, 1) << 7);
          dflt = $urandom_range(0, 255);
        end
      endcase
      drain();
      cfg_write(REG_FINE_STEP, CFG_DATA_W'(fs));
      cfg_write(REG_DEFAULT_DAC, CFG_DATA_W'(dflt));
      if ($urandom_range(0, 3) == 0) cfg_write(REG_NONE, CFG_DATA_W'($urandom_range(0, 255)));
      cfg_write(REG_COARSE_STEP, CFG_DATA_W'(cs));
      cfg_valid <= 1'b0;
      nsearch = (phase_no == 1 || phase_no == 2) ? 1 : $urandom_range(1, 3);
      repeat (nsearch) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3))
            send_beat(CMD_MEASURE, AMP_W'($urandom_range(0, 255)),
                      PH_W'($urandom_range(0, 255)), 1'b0, '0);
        if (phase_no == 1 || phase_no == 2)
          run_search($urandom_range(40, 120));
        else if ($urandom_range(0, 6) == 0)
          run_search($urandom_range(1, 30));
        else
          run_search(260);
      end
      phase_no++;
    end

    drain();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
